### hdl/lbp_pkg.sv
// Shared types and constants of the LSB-first bit packer.
package lbp_pkg;

  // Fixed field widths of the transaction ports
  localparam int unsigned CODE_W = 64;
  localparam int unsigned LEN_W  = 7;
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned PAD_W  = 3;

  // Input command codes
  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_FLUSH = 1'b1;

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EMIT,
    ST_FLUSH
  } state_e;

  // Controller to datapath commands
  typedef struct packed {
    logic load;   // take a write transaction into the byte stream
    logic emit;   // move the next full byte into the output register
    logic flush;  // move the partial byte into the output register
  } dp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic has_bytes;   // incoming write completes at least one byte
    logic final_byte;  // byte at the head of the stream is the last one
    logic slot_free;   // output register can take a result this cycle
  } dp_status_t;

endpackage

### hdl/lsb_first_bit_packer_core.sv
// Top level of the LSB-first bit packer: controller plus datapath.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o) takes one transaction: a write of
//   up to MAX_CODE_BITS code bits (bit 0 first) or a flush of the partial byte.
//   Output channel (out_valid_o / out_stall_i) gives one result per packed byte;
//   last_o marks the final result of a transaction. A write that completes no
//   byte gives no result. A flush gives exactly one result, zero-filled, with
//   pad_bits_o set, or byte_present_o low when nothing is pending.
// Timing:
//   A transaction is loaded into the byte stream register on acceptance; its
//   bytes then move from there into the output register one byte per cycle
//   while the output is not stalled. A write that completes a byte, and a
//   flush, hold the input stalled until their final result is in the output
//   register. The input is taken again while that result still sits there.
// Reset:
//   rst_ni clears the pending byte, the pending count and the output valid.
// Stall:
//   A stalled result holds in the output register; the byte sequencer waits.
module lsb_first_bit_packer_core #(
  parameter int unsigned MAX_CODE_BITS = 64
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic                        command_i,
  input  logic [lbp_pkg::CODE_W-1:0]  code_bits_i,
  input  logic [lbp_pkg::LEN_W-1:0]   code_length_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [lbp_pkg::BYTE_W-1:0]  out_byte_o,
  output logic                        byte_present_o,
  output logic [lbp_pkg::PAD_W-1:0]   pad_bits_o,
  output logic                        last_o
);

  lbp_pkg::dp_cmd_t    dp_cmd;
  lbp_pkg::dp_status_t dp_status;

  lbp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .command_i  (command_i),
    .in_stall_o (in_stall_o),
    .status_i   (dp_status),
    .cmd_o      (dp_cmd)
  );

  lbp_datapath #(
    .MAX_CODE_BITS (MAX_CODE_BITS)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .code_bits_i    (code_bits_i),
    .code_length_i  (code_length_i),
    .cmd_i          (dp_cmd),
    .status_o       (dp_status),
    .out_stall_i    (out_stall_i),
    .out_valid_o    (out_valid_o),
    .out_byte_o     (out_byte_o),
    .byte_present_o (byte_present_o),
    .pad_bits_o     (pad_bits_o),
    .last_o         (last_o)
  );

endmodule

### hdl/lbp_ctrl.sv
// Controller state machine of the LSB-first bit packer.
module lbp_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               command_i,
  output logic               in_stall_o,
  input  lbp_pkg::dp_status_t status_i,
  output lbp_pkg::dp_cmd_t    cmd_o
);

  lbp_pkg::state_e state_q, state_d;
  logic            accept;

  assign accept = in_valid_i && (state_q == lbp_pkg::ST_IDLE);

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lbp_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      lbp_pkg::ST_IDLE: begin
        if (accept) begin
          if (command_i == lbp_pkg::CMD_FLUSH) begin
            state_d = lbp_pkg::ST_FLUSH;
          end else if (status_i.has_bytes) begin
            state_d = lbp_pkg::ST_EMIT;
          end
        end
      end
      lbp_pkg::ST_EMIT: begin
        if (status_i.slot_free && status_i.final_byte) begin
          state_d = lbp_pkg::ST_IDLE;
        end
      end
      lbp_pkg::ST_FLUSH: begin
        if (status_i.slot_free) begin
          state_d = lbp_pkg::ST_IDLE;
        end
      end
      default: state_d = lbp_pkg::ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      lbp_pkg::ST_IDLE: begin
        in_stall_o = 1'b0;
        cmd_o.load = accept && (command_i == lbp_pkg::CMD_WRITE);
      end
      lbp_pkg::ST_EMIT: begin
        cmd_o.emit = status_i.slot_free;
      end
      lbp_pkg::ST_FLUSH: begin
        cmd_o.flush = status_i.slot_free;
      end
      default: begin
        in_stall_o = 1'b1;
      end
    endcase
  end

endmodule

### hdl/lbp_datapath.sv
// Datapath of the LSB-first bit packer: byte stream, pending byte, output register.
module lbp_datapath #(
  parameter int unsigned MAX_CODE_BITS = 64
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic [lbp_pkg::CODE_W-1:0]     code_bits_i,
  input  logic [lbp_pkg::LEN_W-1:0]      code_length_i,
  input  lbp_pkg::dp_cmd_t               cmd_i,
  output lbp_pkg::dp_status_t            status_o,
  input  logic                           out_stall_i,
  output logic                           out_valid_o,
  output logic [lbp_pkg::BYTE_W-1:0]     out_byte_o,
  output logic                           byte_present_o,
  output logic [lbp_pkg::PAD_W-1:0]      pad_bits_o,
  output logic                           last_o
);

  localparam int unsigned MaxBytes = (MAX_CODE_BITS + 7) / 8;
  localparam int unsigned SW       = (MaxBytes + 1) * 8;
  localparam int unsigned BLW      = $clog2(MaxBytes + 1);
  localparam int unsigned TW       = $clog2(MAX_CODE_BITS + 8);

  logic [SW-1:0]                 stream_q, stream_d, stream_load;
  logic [BLW-1:0]                bytes_left_q, bytes_left_d;
  logic [lbp_pkg::BYTE_W-1:0]    pend_byte_q, pend_byte_d;
  logic [lbp_pkg::PAD_W-1:0]     pend_count_q, pend_count_d;
  logic                          out_valid_q, out_valid_d;
  logic [lbp_pkg::BYTE_W-1:0]    out_byte_q, out_byte_d;
  logic                          present_q, present_d;
  logic [lbp_pkg::PAD_W-1:0]     pad_q, pad_d;
  logic                          last_q, last_d;

  logic [lbp_pkg::LEN_W-1:0]     len_sat;
  logic [MAX_CODE_BITS-1:0]      masked;
  logic [TW-1:0]                 total;

  // Length saturation and masking of bits above the length
  always_comb begin
    if (code_length_i > lbp_pkg::LEN_W'(MAX_CODE_BITS)) begin
      len_sat = lbp_pkg::LEN_W'(MAX_CODE_BITS);
    end else begin
      len_sat = code_length_i;
    end
    for (int i = 0; i < MAX_CODE_BITS; i++) begin
      masked[i] = code_bits_i[i] & (lbp_pkg::LEN_W'(i) < len_sat);
    end
  end

  // Append the new code above the pending bits
  assign stream_load = (SW'(masked) << pend_count_q) | SW'(pend_byte_q);
  assign total       = TW'(pend_count_q) + TW'(len_sat);

  // Status toward the controller
  assign status_o.has_bytes  = (total >> 3) != '0;
  assign status_o.final_byte = (bytes_left_q == BLW'(1));
  assign status_o.slot_free  = !out_valid_q || !out_stall_i;

  // Next values of stream and pending state
  always_comb begin
    stream_d     = stream_q;
    bytes_left_d = bytes_left_q;
    pend_byte_d  = pend_byte_q;
    pend_count_d = pend_count_q;
    if (cmd_i.load) begin
      stream_d     = stream_load;
      bytes_left_d = BLW'(total >> 3);
      pend_count_d = total[lbp_pkg::PAD_W-1:0];
      if (!status_o.has_bytes) begin
        pend_byte_d = stream_load[lbp_pkg::BYTE_W-1:0];
      end
    end else if (cmd_i.emit) begin
      stream_d     = stream_q >> lbp_pkg::BYTE_W;
      bytes_left_d = bytes_left_q - BLW'(1);
      if (status_o.final_byte) begin
        pend_byte_d = stream_q[2*lbp_pkg::BYTE_W-1:lbp_pkg::BYTE_W];
      end
    end else if (cmd_i.flush) begin
      pend_byte_d  = '0;
      pend_count_d = '0;
    end
  end

  // Next values of the output register
  always_comb begin
    out_byte_d  = out_byte_q;
    present_d   = present_q;
    pad_d       = pad_q;
    last_d      = last_q;
    out_valid_d = out_valid_q && out_stall_i;
    if (cmd_i.emit) begin
      out_valid_d = 1'b1;
      out_byte_d  = stream_q[lbp_pkg::BYTE_W-1:0];
      present_d   = 1'b1;
      pad_d       = '0;
      last_d      = status_o.final_byte;
    end else if (cmd_i.flush) begin
      // pending bits above the count are zero, so an empty flush shows zero
      out_valid_d = 1'b1;
      out_byte_d  = pend_byte_q;
      present_d   = (pend_count_q != '0);
      pad_d       = '0 - pend_count_q;
      last_d      = 1'b1;
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_byte_q  <= '0;
      pend_count_q <= '0;
      bytes_left_q <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      pend_byte_q  <= pend_byte_d;
      pend_count_q <= pend_count_d;
      bytes_left_q <= bytes_left_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    stream_q   <= stream_d;
    out_byte_q <= out_byte_d;
    present_q  <= present_d;
    pad_q      <= pad_d;
    last_q     <= last_d;
  end

  assign out_valid_o    = out_valid_q;
  assign out_byte_o     = out_byte_q;
  assign byte_present_o = present_q;
  assign pad_bits_o     = pad_q;
  assign last_o         = last_q;

endmodule

### hdl/lbp_checker.sv
// Port-level assertions of the LSB-first bit packer, bound to the top level.
module lbp_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        out_valid_o,
  input logic                        out_stall_i,
  input logic [lbp_pkg::BYTE_W-1:0]  out_byte_o,
  input logic                        byte_present_o,
  input logic [lbp_pkg::PAD_W-1:0]   pad_bits_o,
  input logic                        last_o
);

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_byte_o) && $stable(last_o))
    else $error("stalled result changed");

  // Empty flush result is all zero and final
  a_empty_flush: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !byte_present_o |-> last_o && (pad_bits_o == '0) && (out_byte_o == '0))
    else $error("empty flush result malformed");

  // Padding only on a final flush byte
  a_pad_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (pad_bits_o != '0) |-> last_o && byte_present_o)
    else $error("padding on a non-final or empty result");

  // Intermediate results are full bytes
  a_mid_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_o |-> byte_present_o && (pad_bits_o == '0))
    else $error("intermediate result not a full byte");

endmodule

bind lsb_first_bit_packer_core lbp_checker u_lbp_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .out_byte_o     (out_byte_o),
  .byte_present_o (byte_present_o),
  .pad_bits_o     (pad_bits_o),
  .last_o         (last_o)
);

### verif/tb_lsb_first_bit_packer_core.sv
// Self-checking testbench for the LSB-first bit packer core.
`timescale 1ns / 100ps

module tb_lsb_first_bit_packer_core;

  localparam int unsigned MAX_CODE_BITS = 64;
  localparam int unsigned CYCLE_LIMIT   = 200000;
  localparam int unsigned SETTLE_CYCLES = 20;

  // One packed-byte result as the output channel shows it
  typedef struct packed {
    logic [lbp_pkg::BYTE_W-1:0] data;
    logic                       present;
    logic [lbp_pkg::PAD_W-1:0]  pad;
    logic                       last;
  } byte_result_t;

  logic                       clk_i = 1'b0;
  logic                       rst_ni = 1'b0;
  logic                       in_valid = 1'b0;
  logic                       in_stall_o;
  logic                       command = lbp_pkg::CMD_WRITE;
  logic [lbp_pkg::CODE_W-1:0] code_bits = '0;
  logic [lbp_pkg::LEN_W-1:0]  code_length = '0;
  logic                       out_valid_o;
  logic                       out_stall = 1'b0;
  logic [lbp_pkg::BYTE_W-1:0] out_byte_o;
  logic                       byte_present_o;
  logic [lbp_pkg::PAD_W-1:0]  pad_bits_o;
  logic                       last_o;

  // Bit accumulator of the packer as predicted, and the bytes it should emit
  logic [7:0]        acc_byte = '0;
  logic [3:0]        acc_count = '0;
  byte_result_t      emitted_q[$];

  int unsigned       send_idle_pct = 0;
  int unsigned       recv_idle_pct = 0;
  int unsigned       mismatches = 0;
  int unsigned       cycles = 0;

  lsb_first_bit_packer_core #(
    .MAX_CODE_BITS(MAX_CODE_BITS)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall_o),
    .command_i     (command),
    .code_bits_i   (code_bits),
    .code_length_i (code_length),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall),
    .out_byte_o    (out_byte_o),
    .byte_present_o(byte_present_o),
    .pad_bits_o    (pad_bits_o),
    .last_o        (last_o)
  );

  // 12 ns clock
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Run limit
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // Receiver backpressure
  always @(negedge clk_i) begin
    out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  // Append one accepted transaction to the bit stream and queue the bytes it completes
  function automatic void pack_item(logic cmd, logic [lbp_pkg::CODE_W-1:0] bits,
                                    logic [lbp_pkg::LEN_W-1:0] len);
    byte_result_t fresh[$];
    int unsigned  nbits;
    if (cmd == lbp_pkg::CMD_FLUSH) begin
      if (acc_count != 0)
        fresh.push_back('{acc_byte, 1'b1, lbp_pkg::PAD_W'(4'd8 - acc_count), 1'b1});
      else
        fresh.push_back('{8'h00, 1'b0, 3'd0, 1'b1});
      acc_byte  = '0;
      acc_count = '0;
    end else begin
      nbits = (len > MAX_CODE_BITS) ? MAX_CODE_BITS : len;
      for (int unsigned i = 0; i < nbits; i++) begin
        acc_byte[acc_count[2:0]] = bits[i];
        acc_count = acc_count + 4'd1;
        if (acc_count == 4'd8) begin
          fresh.push_back('{acc_byte, 1'b1, 3'd0, 1'b0});
          acc_byte  = '0;
          acc_count = '0;
        end
      end
      if (fresh.size() > 0) fresh[fresh.size()-1].last = 1'b1;
    end
    foreach (fresh[k]) emitted_q.push_back(fresh[k]);
  endfunction

  task automatic report(string what, byte_result_t want, byte_result_t got);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t %s: exp byte=%02h present=%0b pad=%0d last=%0b,",
               $realtime, what, want.data, want.present, want.pad, want.last,
               " got byte=%02h present=%0b pad=%0d last=%0b",
               got.data, got.present, got.pad, got.last);
  endtask

  // Compare each result against the oldest pending expectation
  always @(posedge clk_i) begin : check_result
    byte_result_t got;
    byte_result_t want;
    if (rst_ni && out_valid_o && !out_stall) begin
      got = '{out_byte_o, byte_present_o, pad_bits_o, last_o};
      if (emitted_q.size() == 0) begin
        report("unexpected result", '0, got);
      end else begin
        want = emitted_q.pop_front();
        if (got.data !== want.data || got.present !== want.present ||
            got.pad !== want.pad || got.last !== want.last)
          report("result mismatch", want, got);
      end
    end
  end

  // Drive one transaction and wait for it to be accepted
  task automatic send_item(logic cmd, logic [lbp_pkg::CODE_W-1:0] bits,
                           logic [lbp_pkg::LEN_W-1:0] len);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk_i);
    end
    in_valid    <= 1'b1;
    command     <= cmd;
    code_bits   <= bits;
    code_length <= len;
    do @(posedge clk_i); while (in_stall_o);
    pack_item(cmd, bits, len);
  endtask

  task automatic release_input();
    @(negedge clk_i);
    in_valid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (emitted_q.size() != 0) @(posedge clk_i);
  endtask

  // Flush with nothing pending, with a partial fill of one and of seven bits, and twice in a row
  task automatic test_flush_handling();
    send_item(lbp_pkg::CMD_FLUSH, '1, 7'd64);
    send_item(lbp_pkg::CMD_WRITE, 64'h1, 7'd1);
    send_item(lbp_pkg::CMD_FLUSH, '0, 7'd0);
    send_item(lbp_pkg::CMD_WRITE, '1, 7'd7);
    send_item(lbp_pkg::CMD_FLUSH, '0, 7'd0);
    send_item(lbp_pkg::CMD_WRITE, 64'h5A5A_5A5A_5A5A_5A5A, 7'd63);
    send_item(lbp_pkg::CMD_FLUSH, '0, 7'd0);
    send_item(lbp_pkg::CMD_FLUSH, '0, 7'd0);
    release_input();
  endtask

  // Zero, saturated and full-width lengths, ignored upper bits, byte boundaries
  task automatic test_length_extremes();
    send_item(lbp_pkg::CMD_WRITE, '1, 7'd0);
    send_item(lbp_pkg::CMD_WRITE, '1, 7'd64);
    send_item(lbp_pkg::CMD_WRITE, 64'h0123_4567_89AB_CDEF, 7'd127);
    send_item(lbp_pkg::CMD_WRITE, 64'hFEDC_BA98_7654_3210, 7'd65);
    send_item(lbp_pkg::CMD_WRITE, 64'hFFFF_FFFF_FFFF_FFF5, 7'd3);
    send_item(lbp_pkg::CMD_WRITE, 64'hFFFF_FFFF_FFFF_FFE6, 7'd5);
    send_item(lbp_pkg::CMD_WRITE, '0, 7'd8);
    send_item(lbp_pkg::CMD_WRITE, 64'h0000_0000_0000_01FF, 7'd9);
    send_item(lbp_pkg::CMD_WRITE, 64'hABC, 7'd12);
    send_item(lbp_pkg::CMD_WRITE, 64'h7, 7'd4);
    send_item(lbp_pkg::CMD_WRITE, '0, 7'd64);
    send_item(lbp_pkg::CMD_WRITE, 64'h8000_0000_0000_0000, 7'd64);
    send_item(lbp_pkg::CMD_WRITE, 64'h3, 7'd2);
    send_item(lbp_pkg::CMD_FLUSH, '0, 7'd0);
    release_input();
  endtask

  // Random mix of writes and flushes, mostly short codes
  task automatic test_random_traffic(int unsigned n_items, int unsigned s_pct,
                                     int unsigned r_pct);
    logic                       cmd;
    logic [lbp_pkg::CODE_W-1:0] bits;
    logic [lbp_pkg::LEN_W-1:0]  len;
    int unsigned                pick;
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    repeat (n_items) begin
      bits = {$urandom, $urandom};
      cmd  = ($urandom_range(99) < 15) ? lbp_pkg::CMD_FLUSH : lbp_pkg::CMD_WRITE;
      pick = $urandom_range(9);
      if (pick < 5)       len = lbp_pkg::LEN_W'($urandom_range(12));
      else if (pick < 7)  len = lbp_pkg::LEN_W'($urandom_range(40, 13));
      else if (pick < 9)  len = lbp_pkg::LEN_W'($urandom_range(64, 41));
      else                len = lbp_pkg::LEN_W'($urandom_range(127, 65));
      send_item(cmd, bits, len);
    end
    release_input();
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    send_idle_pct = 21;
    recv_idle_pct = 45;
    test_flush_handling();
    test_length_extremes();
    test_random_traffic(105, 21, 45);
    // hold the sender off until the packer has drained
    wait_drained();
    test_random_traffic(105, 45, 21);
    test_random_traffic(100, 0, 0);

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && emitted_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

### files.f
hdl/lbp_pkg.sv
hdl/lbp_ctrl.sv
hdl/lbp_datapath.sv
hdl/lsb_first_bit_packer_core.sv
hdl/lbp_checker.sv
verif/tb_lsb_first_bit_packer_core.sv
